// ----- design/alm_pkg.sv -----
// Shared types and constants of the audio level meter.
package alm_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned SampleBits  = 24;
  localparam int unsigned MaxFrames   = 4096;
  localparam int unsigned FrameW      = 13;
  localparam int unsigned SumW        = 60;
  localparam int unsigned LevelW      = 24;
  localparam int unsigned RateW       = 18;
  localparam int unsigned BarW        = 8;
  localparam int unsigned CountW      = 4;
  localparam int unsigned LogCoef     = 6576;

  typedef enum logic [1:0] {
    RegChannelCount = 2'd0,
    RegSampleRate   = 2'd1,
    RegBarWidth     = 2'd2
  } reg_idx_e;

  // Work item handed from the front to the back part.
  typedef struct packed {
    logic               is_end;
    logic               drop;
    logic [ChanW-1:0]   ch;
    logic [2*SampleBits-1:0] sq;
    logic               acc;
    logic               frame_done;
  } alm_cmd_t;

endpackage

// ----- design/alm_front.sv -----
// Front part: classifies each sample and squares its magnitude.
module alm_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic signed [alm_pkg::SampleBits-1:0] sample_i,
  input  logic [alm_pkg::ChanW-1:0]          channel_i,
  input  logic                               end_of_packet_i,
  input  logic                               silent_i,
  input  logic [alm_pkg::CountW-1:0]         eff_ch_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output alm_pkg::alm_cmd_t                  q_cmd_o
);

  logic                          vld_q;
  alm_pkg::alm_cmd_t             cmd_q, cmd_d;
  logic [alm_pkg::SampleBits:0]  mag;
  logic [alm_pkg::CountW-1:0]    ch_ext;

  assign full = vld_q && q_full_i;
  assign ch_ext = {1'b0, channel_i};

  always_comb begin
    if (sample_i[alm_pkg::SampleBits-1]) begin
      mag = -{sample_i[alm_pkg::SampleBits-1], sample_i};
    end else begin
      mag = {1'b0, sample_i};
    end
    cmd_d.is_end     = end_of_packet_i;
    cmd_d.drop       = silent_i;
    cmd_d.ch         = channel_i;
    cmd_d.acc        = ch_ext < eff_ch_i;
    cmd_d.frame_done = ch_ext == eff_ch_i - 4'd1;
    cmd_d.sq         = 48'(mag[alm_pkg::SampleBits-1:0]) * 48'(mag[alm_pkg::SampleBits-1:0]);
    if (mag[alm_pkg::SampleBits]) cmd_d.sq = 48'h4000_0000_0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!full) begin
      vld_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!full && push) cmd_q <= cmd_d;
  end

  assign q_push_o = vld_q;
  assign q_cmd_o  = cmd_q;

endmodule

// ----- design/alm_queue.sv -----
// Short queue between the front and back parts.
module alm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  alm_pkg::alm_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output alm_pkg::alm_cmd_t data_o
);

  alm_pkg::alm_cmd_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 2'd1;
      if (pop_i && !empty_o) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i && !full_o) - 3'(pop_i && !empty_o);
    end
  end

endmodule

// ----- design/alm_back.sv -----
// Back part: accumulation and the per-channel packet-end sequencer.
module alm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  alm_pkg::alm_cmd_t             q_cmd_i,
  output logic                          q_pop_o,
  input  logic [alm_pkg::CountW-1:0]    eff_ch_i,
  input  logic [alm_pkg::RateW-1:0]     rate_i,
  input  logic [alm_pkg::BarW-1:0]      bar_width_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [alm_pkg::ChanW-1:0]     out_channel_o,
  output logic [alm_pkg::LevelW-1:0]    level_o,
  output logic [alm_pkg::BarW-1:0]      bar_length_o,
  output logic                          last_o
);

  typedef enum logic [8:0] {
    SAcc   = 9'b000000001,
    SDiv   = 9'b000000010,
    SSqrt  = 9'b000000100,
    SMix1  = 9'b000001000,
    SMix2  = 9'b000010000,
    SDivR  = 9'b000100000,
    SLog   = 9'b001000000,
    SBar   = 9'b010000000,
    SOut   = 9'b100000000
  } state_e;

  state_e state_q;
  logic [alm_pkg::SumW-1:0]   sum_q [alm_pkg::MaxChannels];
  logic [alm_pkg::LevelW-1:0] lvl_q [alm_pkg::MaxChannels];
  logic [alm_pkg::MaxChannels-1:0] sv_q;
  logic [alm_pkg::FrameW-1:0] fc_q;
  logic [alm_pkg::FrameW-1:0] frames_q;
  logic [alm_pkg::ChanW-1:0]  k_q;
  logic [6:0]  it_q;
  logic [63:0] num_q;
  logic [63:0] rem_q;
  logic [63:0] quo_q;
  logic [63:0] rt_q;
  logic [63:0] bit_q;
  logic [alm_pkg::RateW-1:0] rate_q, n_q;
  logic [47:0] mix_q;
  logic [31:0] y_q;
  logic [4:0]  p_q;
  logic [15:0] frac_q;
  logic [alm_pkg::LevelW-1:0] lv_q;
  logic [alm_pkg::BarW-1:0]   bar_q;
  logic        ovld_q;

  logic        open;
  logic [60:0] add;
  logic [alm_pkg::FrameW-1:0] fr;
  logic [21:0] n10;
  logic [64:0] rtry;
  logic [31:0] sq;
  logic signed [63:0] term;
  logic [alm_pkg::SumW-1:0]   cur_sum;
  logic [alm_pkg::LevelW-1:0] cur_lvl;
  logic [4:0]  msb;

  assign open = fc_q < 13'(alm_pkg::MaxFrames);
  assign add  = {1'b0, sum_q[q_cmd_i.ch]} + 61'(q_cmd_i.sq);
  assign cur_sum = sv_q[k_q] ? sum_q[k_q] : '0;
  assign cur_lvl = lvl_q[k_q];
  assign empty = !ovld_q;
  assign q_pop_o = (state_q == SAcc) && !q_empty_i;

  always_comb begin
    // Whatever the end item's channel, an open packet gains one frame at its end.
    fr = fc_q + 13'(open);
    if (fr == '0) fr = 13'd1;
    n10 = 22'(frames_q) * 22'd10;
    rtry = {1'b0, rem_q} - ({1'b0, rt_q} + {1'b0, bit_q});
    sq = 32'((64'(y_q) * 64'(y_q)) >> 30);
    term = 64'sh1_0000_0000 +
           (($signed({43'd0, p_q, frac_q}) - 64'sd1572864) *
            $signed(64'(alm_pkg::LogCoef)));
    msb = '0;
    for (int i = 0; i < 24; i++) if (lv_q[i]) msb = 5'(i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SAcc;
      sv_q <= '0;
      fc_q <= '0;
      ovld_q <= 1'b0;
      for (int i = 0; i < alm_pkg::MaxChannels; i++) lvl_q[i] <= '0;
    end else begin
      if (ovld_q && pop && state_q != SOut) ovld_q <= 1'b0;
      unique case (state_q)
        SAcc: begin
          if (!q_empty_i) begin
            if (q_cmd_i.is_end && q_cmd_i.drop) begin
              // A silent packet is discarded whole.
              sv_q <= '0;
              fc_q <= '0;
            end else begin
              if (open && q_cmd_i.acc) begin
                sum_q[q_cmd_i.ch] <= !sv_q[q_cmd_i.ch] ? 60'(q_cmd_i.sq) :
                                     (add[60] ? {60{1'b1}} : add[59:0]);
                sv_q[q_cmd_i.ch] <= 1'b1;
                if (q_cmd_i.frame_done) fc_q <= fc_q + 13'd1;
              end
              if (q_cmd_i.is_end) begin
                frames_q <= fr;
                k_q <= '0;
                rate_q <= (rate_i == '0) ? 18'd1 : rate_i;
                it_q <= '0;
                state_q <= SDiv;
              end
            end
          end
        end
        SDiv: begin
          // Restoring divide, one quotient bit per cycle.
          if (it_q == 7'd0) begin
            rem_q <= '0;
            quo_q <= {4'd0, cur_sum};
            it_q <= 7'd1;
          end else begin
            if ({rem_q[62:0], quo_q[59]} >= 64'(frames_q)) begin
              rem_q <= {rem_q[62:0], quo_q[59]} - 64'(frames_q);
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= {rem_q[62:0], quo_q[59]};
              quo_q <= {quo_q[62:0], 1'b0};
            end
            if (it_q == 7'd60) begin
              it_q <= '0;
              state_q <= SSqrt;
            end else it_q <= it_q + 7'd1;
          end
        end
        SSqrt: begin
          if (it_q == 7'd0) begin
            rem_q <= {2'b00, quo_q[59:0], 2'b00};
            rt_q  <= '0;
            bit_q <= 64'h4000_0000_0000_0000;
            it_q  <= 7'd1;
          end else begin
            if (!rtry[64]) begin
              rem_q <= rtry[63:0];
              rt_q  <= (rt_q >> 1) + bit_q;
            end else rt_q <= rt_q >> 1;
            bit_q <= bit_q >> 2;
            if (it_q == 7'd32) begin
              it_q <= '0;
              state_q <= SMix1;
            end else it_q <= it_q + 7'd1;
          end
        end
        SMix1: begin
          if (rt_q > 64'hFF_FFFF) rt_q <= 64'hFF_FFFF;
          n_q <= (n10 > 22'(rate_q)) ? rate_q : n10[17:0];
          state_q <= SMix2;
        end
        SMix2: begin
          if (it_q == 7'd0) begin
            mix_q <= 48'(cur_lvl) * 48'(rate_q - n_q);
            it_q <= 7'd1;
          end else begin
            num_q <= 64'(mix_q) + 64'(rt_q[23:0]) * 64'(n_q) + 64'(rate_q >> 1);
            it_q <= '0;
            state_q <= SDivR;
          end
        end
        SDivR: begin
          if (it_q == 7'd0) begin
            rem_q <= '0;
            quo_q <= num_q;
            it_q <= 7'd1;
          end else begin
            if ({rem_q[62:0], quo_q[47]} >= 64'(rate_q)) begin
              rem_q <= {rem_q[62:0], quo_q[47]} - 64'(rate_q);
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= {rem_q[62:0], quo_q[47]};
              quo_q <= {quo_q[62:0], 1'b0};
            end
            if (it_q == 7'd48) begin
              it_q <= '0;
              state_q <= SLog;
            end else it_q <= it_q + 7'd1;
          end
        end
        SLog: begin
          if (it_q == 7'd0) begin
            lv_q <= (quo_q[47:0] > 48'hFF_FFFF) ? 24'hFF_FFFF : quo_q[23:0];
            it_q <= 7'd1;
          end else if (it_q == 7'd1) begin
            lvl_q[k_q] <= lv_q;
            p_q <= msb;
            y_q <= 32'(lv_q) << (5'd30 - msb);
            frac_q <= '0;
            it_q <= 7'd2;
          end else begin
            if (sq >= 32'h8000_0000) begin
              y_q <= sq >> 1;
              frac_q <= {frac_q[14:0], 1'b1};
            end else begin
              y_q <= sq;
              frac_q <= {frac_q[14:0], 1'b0};
            end
            if (it_q == 7'd17) begin
              it_q <= '0;
              state_q <= SBar;
            end else it_q <= it_q + 7'd1;
          end
        end
        SBar: begin
          if (lv_q == '0 || term <= 0) bar_q <= '0;
          else begin
            logic [40:0] b;
            b = 41'((64'(bar_width_i) * 64'(term)) >> 32);
            bar_q <= (b > 41'(bar_width_i)) ? bar_width_i : b[7:0];
          end
          state_q <= SOut;
        end
        SOut: begin
          if (!ovld_q || pop) begin
            ovld_q <= 1'b1;
            out_channel_o <= k_q;
            level_o <= lv_q;
            bar_length_o <= bar_q;
            last_o <= ({1'b0, k_q} == eff_ch_i - 4'd1);
            if ({1'b0, k_q} == eff_ch_i - 4'd1) begin
              sv_q <= '0;
              fc_q <= '0;
              state_q <= SAcc;
            end else begin
              k_q <= k_q + 3'd1;
              state_q <= SDiv;
            end
          end
        end
        default: state_q <= SAcc;
      endcase
    end
  end

endmodule

// ----- design/audio_level_meter_unit.sv -----
// Top level of the audio level meter: registers, front, queue and back.
// Samples are accepted through a queue-style port (push/full) at up to one
// transaction per clock into a four-entry queue; the back part accumulates them
// while it waits for a packet end. At packet end the back part walks the channels
// one at a time: a restoring divide of the sum of squares by the frame count,
// a square root, a smoothing multiply, a divide by the sample rate, a log2 by
// repeated squaring, then the bar and the output.
// Results leave through empty/pop; samples keep queueing meanwhile.
module audio_level_meter_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [alm_pkg::SampleBits-1:0] sample_i,
  input  logic [alm_pkg::ChanW-1:0]             channel_i,
  input  logic                                  end_of_packet_i,
  input  logic                                  silent_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [alm_pkg::ChanW-1:0]             out_channel_o,
  output logic [alm_pkg::LevelW-1:0]            level_o,
  output logic [alm_pkg::BarW-1:0]              bar_length_o,
  output logic                                  last_o,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [alm_pkg::RateW-1:0]             cfg_data_i
);

  logic [alm_pkg::CountW-1:0] cc_q;
  logic [alm_pkg::RateW-1:0]  rate_q;
  logic [alm_pkg::BarW-1:0]   bw_q;
  logic [alm_pkg::CountW-1:0] eff_ch;
  logic q_full, q_push, q_empty, q_pop;
  alm_pkg::alm_cmd_t f_cmd, b_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 4'd2;
      rate_q <= 18'd48000;
      bw_q <= 8'd80;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        alm_pkg::RegChannelCount: cc_q <= cfg_data_i[3:0];
        alm_pkg::RegSampleRate:   rate_q <= cfg_data_i;
        alm_pkg::RegBarWidth:     bw_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The effective channel count is at least one and at most eight.
  assign eff_ch = (cc_q == '0) ? 4'd1 : ((cc_q > 4'd8) ? 4'd8 : cc_q);

  alm_front u_front (
    .clk_i, .rst_ni, .push, .full, .sample_i, .channel_i, .end_of_packet_i,
    .silent_i, .eff_ch_i(eff_ch), .q_full_i(q_full), .q_push_o(q_push),
    .q_cmd_o(f_cmd)
  );

  alm_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(f_cmd), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(b_cmd)
  );

  alm_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_cmd_i(b_cmd), .q_pop_o(q_pop),
    .eff_ch_i(eff_ch), .rate_i(rate_q), .bar_width_i(bw_q), .empty, .pop,
    .out_channel_o, .level_o, .bar_length_o, .last_o
  );

endmodule
